@@ rtl/kab_pkg.sv @@
// kab_pkg: shared sizes, constants, codes and stage structs for the
// kick-angle bilinear compensation block. No dependencies.
package kab_pkg;

   // table geometry
   localparam int ROBOT_COUNT = 16;
   localparam int SPEED_ROWS  = 92;
   localparam int ANGLE_COLS  = 17;

   // field widths
   localparam int ROBOT_W = 4;
   localparam int SPEED_W = 14;
   localparam int ANG_W   = 13;
   localparam int ROW_W   = 7;
   localparam int COL_W   = 5;
   localparam int VAL_W   = 16;
   localparam int CAP_W   = 11;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = SPEED_W;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_SPEED_CUTOFF = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_CAP        = 1'b1;
   localparam logic [SPEED_W-1:0]   CUTOFF_RESET = 14'd160;
   localparam logic [CAP_W-1:0]     CAP_RESET    = 11'd1280;

   // item kind
   localparam logic ACT_LOOKUP = 1'b0;
   localparam logic ACT_WRITE  = 1'b1;

   // arithmetic constants: one cell is 80 units on both axes
   localparam int CELL       = 80;
   localparam int SPEED_LO   = 3120;
   localparam int SPEED_HI   = 10400;
   localparam int S_CAP      = ((SPEED_ROWS - 1) * CELL < SPEED_HI - SPEED_LO) ?
                               (SPEED_ROWS - 1) * CELL : SPEED_HI - SPEED_LO;
   localparam int A_LIMIT    = (ANGLE_COLS - 1) * CELL;
   localparam int ROUND_HALF = CELL * CELL / 2;

   // x/80 = (x>>4)/5, y/5 = (y*205)>>10 for y < 1024
   localparam int CELL_SHIFT = 4;
   localparam int DIV5_MUL   = 205;
   localparam int DIV5_SHIFT = 10;
   // x/6400 = (x>>8)/25, y/25 = (y*K)>>25, exact for y < 2^20
   localparam int AREA_SHIFT  = 8;
   localparam int DIV25_MUL   = 1342178;
   localparam int DIV25_W     = 21;
   localparam int DIV25_SHIFT = 25;

   // datapath widths
   localparam int OFS_W   = 13;   // clamped speed offset, max 7280
   localparam int MAG_W   = CAP_W; // capped angle magnitude
   localparam int WGT_W   = 7;    // 0..80
   localparam int PROD_W  = 24;   // weight * word
   localparam int SUM_W   = 32;   // blended sum, fits in 29 signed bits
   localparam int RND_W   = 28;   // |sum| + half
   localparam int QPROD_W = RND_W - AREA_SHIFT + DIV25_W;
   localparam int QUOT_W  = QPROD_W - DIV25_SHIFT;
   localparam logic signed [VAL_W-1:0] VAL_MAX = 16'sh7FFF;

   // four banks split by row and column parity, so the four corners of
   // a cell always fall in different banks
   localparam int NUM_BANKS  = 4;
   localparam int HALF_ROWS  = (SPEED_ROWS + 1) / 2;
   localparam int HALF_COLS  = (ANGLE_COLS + 1) / 2;
   localparam int BANK_DEPTH = ROBOT_COUNT * HALF_ROWS * HALF_COLS;
   localparam int BANK_AW    = $clog2(BANK_DEPTH);

   typedef logic [BANK_AW-1:0]      bank_addr_type;
   typedef logic signed [VAL_W-1:0] word_type;

   // prep -> table
   typedef struct packed {
      logic                           is_write;
      bank_addr_type [NUM_BANKS-1:0]  rd_addr;
      logic [NUM_BANKS-1:0]           wr_en;
      bank_addr_type                  wr_addr;
      word_type                       wr_data;
      logic                           row_odd;
      logic                           col_odd;
      logic [WGT_W-1:0]               du;
      logic [WGT_W-1:0]               dl;
      logic                           zero;
      logic                           pos;
   } access_type;

   // table -> blend
   typedef struct packed {
      word_type [NUM_BANKS-1:0] word;
      logic                     row_odd;
      logic                     col_odd;
      logic [WGT_W-1:0]         du;
      logic [WGT_W-1:0]         dl;
      logic                     zero;
      logic                     pos;
   } corner_type;

   // blend -> round
   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic                    zero;
      logic                    pos;
   } blend_type;

   function automatic bank_addr_type bank_addr(input logic [ROBOT_W-1:0] robot,
                                               input logic [ROW_W-2:0]   hrow,
                                               input logic [COL_W-2:0]   hcol);
      int lin;
      lin = (int'(robot) * HALF_ROWS + int'(hrow)) * HALF_COLS + int'(hcol);
      return BANK_AW'(lin);
   endfunction

endpackage

@@ rtl/kab_prep.sv @@
// kab_prep: three stages - clamp/cap, cell index and weights, bank addresses.
// Depends on kab_pkg.
module kab_prep (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic                           in_action,
   input  logic [kab_pkg::ROBOT_W-1:0]    in_robot,
   input  logic [kab_pkg::SPEED_W-1:0]    in_ball_speed,
   input  logic signed [kab_pkg::ANG_W-1:0] in_angle_diff,
   input  logic [kab_pkg::ROW_W-1:0]      in_row_addr,
   input  logic [kab_pkg::COL_W-1:0]      in_col_addr,
   input  logic signed [kab_pkg::VAL_W-1:0] in_entry_value,
   input  logic [kab_pkg::SPEED_W-1:0]    low_speed_cutoff,
   input  logic [kab_pkg::CAP_W-1:0]      angle_cap,
   output logic                           out_valid,
   input  logic                           out_ready,
   output kab_pkg::access_type            out_access
);
   import kab_pkg::*;

   logic en_a, en_b, en_c;

   // stage A
   logic                 a_valid_ff;
   logic                 a_write_ff, a_legal_ff, a_zero_ff, a_pos_ff;
   logic [ROBOT_W-1:0]   a_robot_ff;
   logic [OFS_W-1:0]     a_s_ff;
   logic [MAG_W-1:0]     a_a_ff;
   logic [ROW_W-1:0]     a_row_addr_ff;
   logic [COL_W-1:0]     a_col_addr_ff;
   word_type             a_data_ff;
   logic [SPEED_W-1:0]   spd_clamp, spd_ofs;
   logic [ANG_W-1:0]     ang_raw, ang_mag, ang_lim;
   logic [OFS_W-1:0]     a_s_in;
   logic [MAG_W-1:0]     a_a_in;
   logic                 a_legal_in, a_zero_in, a_pos_in;

   // stage B
   logic                 b_valid_ff;
   logic                 b_write_ff, b_legal_ff, b_zero_ff, b_pos_ff;
   logic [ROBOT_W-1:0]   b_robot_ff;
   logic [ROW_W-1:0]     b_row_ff;
   logic [COL_W-1:0]     b_col_ff;
   logic [WGT_W-1:0]     b_du_ff, b_dl_ff;
   word_type             b_data_ff;
   logic [ROW_W-1:0]     row_q, row_l;
   logic [COL_W-1:0]     col_q, col_l;
   logic [ROW_W-1:0]     b_row_in;
   logic [COL_W-1:0]     b_col_in;
   logic [WGT_W-1:0]     b_du_in, b_dl_in;

   // stage C
   logic                 c_valid_ff;
   access_type           c_access_ff;
   access_type           c_access_in;
   logic [ROW_W-1:0]     rsel;
   logic [COL_W-1:0]     csel;

   // ceil-style cell index: floor((x+79)/80)
   function automatic logic [ROW_W-1:0] cell_index(input logic [SPEED_W-1:0] x);
      logic [SPEED_W-1:0]            up;
      logic [SPEED_W-CELL_SHIFT-1:0] y;
      logic [SPEED_W+3:0]            p;
      up = x + SPEED_W'(CELL - 1);
      y  = up[SPEED_W-1:CELL_SHIFT];
      p  = (SPEED_W + 4)'(y) * (SPEED_W + 4)'(DIV5_MUL);
      return ROW_W'(p >> DIV5_SHIFT);
   endfunction

   always_comb begin
      en_c     = !c_valid_ff || out_ready;
      en_b     = !b_valid_ff || en_c;
      en_a     = !a_valid_ff || en_b;
      in_ready = en_a;
   end

   // ---------------- stage A: clamp speed, cap angle magnitude
   always_comb begin
      spd_clamp = in_ball_speed;
      if (in_ball_speed < SPEED_W'(SPEED_LO)) begin
         spd_clamp = SPEED_W'(SPEED_LO);
      end else if (in_ball_speed > SPEED_W'(SPEED_HI)) begin
         spd_clamp = SPEED_W'(SPEED_HI);
      end
      spd_ofs = spd_clamp - SPEED_W'(SPEED_LO);
      if (spd_ofs > SPEED_W'(S_CAP)) begin
         spd_ofs = SPEED_W'(S_CAP);
      end
      a_s_in = OFS_W'(spd_ofs);

      ang_raw = in_angle_diff;
      ang_mag = ang_raw[ANG_W-1] ? ANG_W'(~ang_raw + 1'b1) : ang_raw;
      ang_lim = ang_mag;
      if (ang_lim > ANG_W'(angle_cap)) begin
         ang_lim = ANG_W'(angle_cap);
      end
      if (ang_lim > ANG_W'(A_LIMIT)) begin
         ang_lim = ANG_W'(A_LIMIT);
      end
      a_a_in = MAG_W'(ang_lim);

      a_zero_in  = (32'(in_robot) >= ROBOT_COUNT) || (in_ball_speed < low_speed_cutoff);
      a_pos_in   = !ang_raw[ANG_W-1] && (ang_raw != '0);
      a_legal_in = (32'(in_robot) < ROBOT_COUNT) && (32'(in_row_addr) < SPEED_ROWS) &&
                   (32'(in_col_addr) < ANGLE_COLS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en_a) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_write_ff    <= (in_action == ACT_WRITE);
         a_legal_ff    <= a_legal_in;
         a_zero_ff     <= a_zero_in;
         a_pos_ff      <= a_pos_in;
         a_robot_ff    <= in_robot;
         a_s_ff        <= a_s_in;
         a_a_ff        <= a_a_in;
         a_row_addr_ff <= in_row_addr;
         a_col_addr_ff <= in_col_addr;
         a_data_ff     <= in_entry_value;
      end
   end

   // ---------------- stage B: cell index and corner weights
   always_comb begin
      row_q = cell_index(SPEED_W'(a_s_ff));
      col_q = COL_W'(cell_index(SPEED_W'(a_a_ff)));
      row_l = (row_q == '0) ? ROW_W'(1) : row_q;
      col_l = (col_q == '0) ? COL_W'(1) : col_q;
      b_du_in = WGT_W'(SPEED_W'(a_s_ff) - SPEED_W'(row_l - 1'b1) * SPEED_W'(CELL));
      b_dl_in = WGT_W'(SPEED_W'(a_a_ff) - SPEED_W'(col_l - 1'b1) * SPEED_W'(CELL));
      // a write item carries its own address through the same fields
      b_row_in = a_write_ff ? a_row_addr_ff : row_l;
      b_col_in = a_write_ff ? a_col_addr_ff : col_l;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en_b) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         b_write_ff <= a_write_ff;
         b_legal_ff <= a_legal_ff;
         b_zero_ff  <= a_zero_ff;
         b_pos_ff   <= a_pos_ff;
         b_robot_ff <= a_robot_ff;
         b_row_ff   <= b_row_in;
         b_col_ff   <= b_col_in;
         b_du_ff    <= b_du_in;
         b_dl_ff    <= b_dl_in;
         b_data_ff  <= a_data_ff;
      end
   end

   // ---------------- stage C: per-bank addresses
   // bank {p,q} holds rows of parity p and columns of parity q
   always_comb begin
      rsel = b_row_ff;
      csel = b_col_ff;
      c_access_in.is_write = b_write_ff;
      c_access_in.wr_addr  = bank_addr(b_robot_ff, b_row_ff[ROW_W-1:1], b_col_ff[COL_W-1:1]);
      c_access_in.wr_data  = b_data_ff;
      c_access_in.row_odd  = b_row_ff[0];
      c_access_in.col_odd  = b_col_ff[0];
      c_access_in.du       = b_du_ff;
      c_access_in.dl       = b_dl_ff;
      c_access_in.zero     = b_zero_ff;
      c_access_in.pos      = b_pos_ff;
      for (int k = 0; k < NUM_BANKS; k++) begin
         rsel = (b_row_ff[0] == k[1]) ? b_row_ff : b_row_ff - 1'b1;
         csel = (b_col_ff[0] == k[0]) ? b_col_ff : b_col_ff - 1'b1;
         c_access_in.rd_addr[k] = bank_addr(b_robot_ff, rsel[ROW_W-1:1], csel[COL_W-1:1]);
         c_access_in.wr_en[k]   = b_write_ff && b_legal_ff &&
                                  (2'(k) == {b_row_ff[0], b_col_ff[0]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en_c) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_c) begin
         c_access_ff <= c_access_in;
      end
   end

   assign out_valid  = c_valid_ff;
   assign out_access = c_access_ff;

endmodule

@@ rtl/kab_table.sv @@
// kab_table: four parity banks of correction words, at most one write and
// four reads per item, registered read data. Depends on kab_pkg.
module kab_table (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  kab_pkg::access_type in_access,
   output logic                out_valid,
   input  logic                out_ready,
   output kab_pkg::corner_type out_corner
);
   import kab_pkg::*;

   logic             en_d;
   logic             d_valid_ff;
   logic             d_write_ff;
   logic             d_row_odd_ff, d_col_odd_ff, d_zero_ff, d_pos_ff;
   logic [WGT_W-1:0] d_du_ff, d_dl_ff;
   word_type         rd_word [NUM_BANKS];

   // a write item retires here and never waits on the next stage
   assign en_d     = !d_valid_ff || out_ready || d_write_ff;
   assign in_ready = en_d;

   for (genvar k = 0; k < NUM_BANKS; k++) begin : g_bank
      word_type bank_mem [BANK_DEPTH];
      word_type rd_ff;

      always_ff @(posedge clock) begin
         if (en_d && in_valid) begin
            if (in_access.wr_en[k]) begin
               bank_mem[in_access.wr_addr] <= in_access.wr_data;
            end
            rd_ff <= bank_mem[in_access.rd_addr[k]];
         end
      end

      assign rd_word[k] = rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         d_write_ff <= 1'b0;
      end else if (en_d) begin
         d_valid_ff <= in_valid;
         d_write_ff <= in_access.is_write;
      end
   end

   always_ff @(posedge clock) begin
      if (en_d) begin
         d_row_odd_ff <= in_access.row_odd;
         d_col_odd_ff <= in_access.col_odd;
         d_du_ff      <= in_access.du;
         d_dl_ff      <= in_access.dl;
         d_zero_ff    <= in_access.zero;
         d_pos_ff     <= in_access.pos;
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_BANKS; k++) begin
         out_corner.word[k] = rd_word[k];
      end
      out_corner.row_odd = d_row_odd_ff;
      out_corner.col_odd = d_col_odd_ff;
      out_corner.du      = d_du_ff;
      out_corner.dl      = d_dl_ff;
      out_corner.zero    = d_zero_ff;
      out_corner.pos     = d_pos_ff;
   end

   assign out_valid = d_valid_ff && !d_write_ff;

endmodule

@@ rtl/kab_blend.sv @@
// kab_blend: four stages - corner products, row sums, row weighting,
// final sum of the bilinear blend. Depends on kab_pkg.
module kab_blend (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  kab_pkg::corner_type in_corner,
   output logic                out_valid,
   input  logic                out_ready,
   output kab_pkg::blend_type  out_blend
);
   import kab_pkg::*;

   logic en_e, en_f, en_g, en_h;

   // stage E
   logic                     e_valid_ff;
   logic signed [PROD_W-1:0] e_prod_ff [NUM_BANKS];
   logic signed [PROD_W-1:0] e_prod_in [NUM_BANKS];
   logic [WGT_W-1:0]         e_du_ff, e_dd_ff;
   logic                     e_zero_ff, e_pos_ff;
   logic [WGT_W-1:0]         dr, dd;
   logic [1:0]               i00, i01, i10, i11;

   // stage F
   logic                     f_valid_ff;
   logic signed [PROD_W-1:0] f_top_ff, f_bot_ff;
   logic [WGT_W-1:0]         f_du_ff, f_dd_ff;
   logic                     f_zero_ff, f_pos_ff;

   // stage G
   logic                     g_valid_ff;
   logic signed [SUM_W-1:0]  g_mt_ff, g_mb_ff;
   logic                     g_zero_ff, g_pos_ff;

   // stage H
   logic                     h_valid_ff;
   blend_type                h_blend_ff;

   always_comb begin
      en_h     = !h_valid_ff || out_ready;
      en_g     = !g_valid_ff || en_h;
      en_f     = !f_valid_ff || en_g;
      en_e     = !e_valid_ff || en_f;
      in_ready = en_e;
   end

   // ---------------- stage E: corner * column weight
   always_comb begin
      dr  = WGT_W'(CELL) - in_corner.dl;
      dd  = WGT_W'(CELL) - in_corner.du;
      // upper row / left column have the opposite parity of row / col
      i00 = {~in_corner.row_odd, ~in_corner.col_odd};
      i01 = {~in_corner.row_odd,  in_corner.col_odd};
      i10 = { in_corner.row_odd, ~in_corner.col_odd};
      i11 = { in_corner.row_odd,  in_corner.col_odd};
      e_prod_in[0] = PROD_W'(signed'({1'b0, dr})) * PROD_W'(in_corner.word[i00]);
      e_prod_in[1] = PROD_W'(signed'({1'b0, in_corner.dl})) * PROD_W'(in_corner.word[i01]);
      e_prod_in[2] = PROD_W'(signed'({1'b0, dr})) * PROD_W'(in_corner.word[i10]);
      e_prod_in[3] = PROD_W'(signed'({1'b0, in_corner.dl})) * PROD_W'(in_corner.word[i11]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
      end else begin
         if (en_e) begin
            e_valid_ff <= in_valid;
         end
         if (en_f) begin
            f_valid_ff <= e_valid_ff;
         end
         if (en_g) begin
            g_valid_ff <= f_valid_ff;
         end
         if (en_h) begin
            h_valid_ff <= g_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_e) begin
         for (int k = 0; k < NUM_BANKS; k++) begin
            e_prod_ff[k] <= e_prod_in[k];
         end
         e_du_ff   <= in_corner.du;
         e_dd_ff   <= dd;
         e_zero_ff <= in_corner.zero;
         e_pos_ff  <= in_corner.pos;
      end
   end

   // ---------------- stage F: row sums
   always_ff @(posedge clock) begin
      if (en_f) begin
         f_top_ff  <= e_prod_ff[0] + e_prod_ff[1];
         f_bot_ff  <= e_prod_ff[2] + e_prod_ff[3];
         f_du_ff   <= e_du_ff;
         f_dd_ff   <= e_dd_ff;
         f_zero_ff <= e_zero_ff;
         f_pos_ff  <= e_pos_ff;
      end
   end

   // ---------------- stage G: row * speed weight
   always_ff @(posedge clock) begin
      if (en_g) begin
         g_mt_ff   <= SUM_W'(f_top_ff) * SUM_W'(signed'({1'b0, f_dd_ff}));
         g_mb_ff   <= SUM_W'(f_bot_ff) * SUM_W'(signed'({1'b0, f_du_ff}));
         g_zero_ff <= f_zero_ff;
         g_pos_ff  <= f_pos_ff;
      end
   end

   // ---------------- stage H: blended sum
   always_ff @(posedge clock) begin
      if (en_h) begin
         h_blend_ff.sum  <= g_mt_ff + g_mb_ff;
         h_blend_ff.zero <= g_zero_ff;
         h_blend_ff.pos  <= g_pos_ff;
      end
   end

   assign out_valid = h_valid_ff;
   assign out_blend = h_blend_ff;

endmodule

@@ rtl/kab_round.sv @@
// kab_round: two stages - round |sum|/6400 by reciprocal multiply, then
// sign, zero force and saturation into the output register. Depends on kab_pkg.
module kab_round (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  kab_pkg::blend_type             in_blend,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic signed [kab_pkg::VAL_W-1:0] out_compensation
);
   import kab_pkg::*;

   logic en_i, en_j;

   logic                 i_valid_ff;
   logic [QPROD_W-1:0]   i_prod_ff;
   logic                 i_neg_ff, i_zero_ff;
   logic [SUM_W-1:0]     sum_mag;
   logic [RND_W-1:0]     rnd;
   logic [QPROD_W-1:0]   i_prod_in;

   logic                 j_valid_ff;
   word_type             j_comp_ff;
   logic [QUOT_W-1:0]    quot;
   logic [QUOT_W:0]      quot_x;
   word_type             j_comp_in;

   always_comb begin
      en_j     = !j_valid_ff || out_ready;
      en_i     = !i_valid_ff || en_j;
      in_ready = en_i;
   end

   // ---------------- stage I: magnitude, round half away, times 1/25
   always_comb begin
      sum_mag   = in_blend.sum[SUM_W-1] ? SUM_W'(-in_blend.sum) : SUM_W'(in_blend.sum);
      rnd       = RND_W'(sum_mag + SUM_W'(ROUND_HALF));
      i_prod_in = QPROD_W'(rnd[RND_W-1:AREA_SHIFT]) * QPROD_W'(DIV25_MUL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_valid_ff <= 1'b0;
         j_valid_ff <= 1'b0;
      end else begin
         if (en_i) begin
            i_valid_ff <= in_valid;
         end
         if (en_j) begin
            j_valid_ff <= i_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_i) begin
         i_prod_ff <= i_prod_in;
         // zero angle counts as negative
         i_neg_ff  <= in_blend.sum[SUM_W-1] ^ !in_blend.pos;
         i_zero_ff <= in_blend.zero;
      end
   end

   // ---------------- stage J: zero force, sign and saturate
   always_comb begin
      quot   = i_prod_ff[QPROD_W-1:DIV25_SHIFT];
      quot_x = {1'b0, quot};
      if (i_zero_ff) begin
         j_comp_in = '0;
      end else if (i_neg_ff) begin
         j_comp_in = VAL_W'(~quot_x + 1'b1);
      end else if (quot > QUOT_W'(VAL_MAX)) begin
         j_comp_in = VAL_MAX;
      end else begin
         j_comp_in = VAL_W'(quot);
      end
   end

   always_ff @(posedge clock) begin
      if (en_j) begin
         j_comp_ff <= j_comp_in;
      end
   end

   assign out_valid        = j_valid_ff;
   assign out_compensation = j_comp_ff;

endmodule

@@ rtl/kick_angle_bilinear_compensation_top.sv @@
// kick_angle_bilinear_compensation_top: per-robot kick-angle correction by
// bilinear table interpolation. Depends on kab_pkg, kab_prep, kab_table,
// kab_blend and kab_round.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+----------------------------------------
//   req     | in  | req_valid/ready    | action, robot, ball_speed, angle_diff,
//           |     |                    | row_addr, col_addr, entry_value
//   rsp     | out | rsp_valid/ready    | compensation (one item per lookup)
//   csr     | in  | csr_wr_en          | csr_index, csr_wr_data (write only)
//
// Throughput: one item per clock unless rsp_ready low holds the stages back.
//   A lookup passes 3 prep stages, 1 table read, 4 blend stages and 2 round
//   stages; the depth is set by the four-bank table read and the two
//   multiplier levels of the blend plus the reciprocal divide.
// Write items store their word at the table stage and give no result.
// Reset clears valid bits and the two config registers; table contents are
//   undefined until written.
// Stalls: rsp_ready low holds the stages back one by one; empty stages keep
//   filling, and a write item in the table stage never waits.
module kick_angle_bilinear_compensation_top (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_action,
   input  logic [kab_pkg::ROBOT_W-1:0]       req_robot,
   input  logic [kab_pkg::SPEED_W-1:0]       req_ball_speed,
   input  logic signed [kab_pkg::ANG_W-1:0]  req_angle_diff,
   input  logic [kab_pkg::ROW_W-1:0]         req_row_addr,
   input  logic [kab_pkg::COL_W-1:0]         req_col_addr,
   input  logic signed [kab_pkg::VAL_W-1:0]  req_entry_value,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [kab_pkg::VAL_W-1:0]  rsp_compensation,
   // config write port
   input  logic                              csr_wr_en,
   input  logic [kab_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kab_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import kab_pkg::*;

   // config registers
   logic [SPEED_W-1:0] cutoff_ff, cutoff_in;
   logic [CAP_W-1:0]   cap_ff, cap_in;

   // inter-stage links
   logic       prep_valid, prep_ready;
   access_type prep_access;
   logic       tab_valid, tab_ready;
   corner_type tab_corner;
   logic       blend_valid, blend_ready;
   blend_type  blend_out;

   // ---------------- config
   always_comb begin
      cutoff_in = cutoff_ff;
      cap_in    = cap_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_LOW_SPEED_CUTOFF: begin
               cutoff_in = csr_wr_data;
            end
            CSR_ANGLE_CAP: begin
               cap_in = csr_wr_data[CAP_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= CUTOFF_RESET;
         cap_ff    <= CAP_RESET;
      end else begin
         cutoff_ff <= cutoff_in;
         cap_ff    <= cap_in;
      end
   end

   // ---------------- clamp, cell index, bank addressing
   kab_prep u_prep (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (req_valid),
      .in_ready         (req_ready),
      .in_action        (req_action),
      .in_robot         (req_robot),
      .in_ball_speed    (req_ball_speed),
      .in_angle_diff    (req_angle_diff),
      .in_row_addr      (req_row_addr),
      .in_col_addr      (req_col_addr),
      .in_entry_value   (req_entry_value),
      .low_speed_cutoff (cutoff_ff),
      .angle_cap        (cap_ff),
      .out_valid        (prep_valid),
      .out_ready        (prep_ready),
      .out_access       (prep_access)
   );

   // ---------------- table banks: writes retire here
   kab_table u_table (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (prep_valid),
      .in_ready   (prep_ready),
      .in_access  (prep_access),
      .out_valid  (tab_valid),
      .out_ready  (tab_ready),
      .out_corner (tab_corner)
   );

   // ---------------- bilinear blend
   kab_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (tab_valid),
      .in_ready  (tab_ready),
      .in_corner (tab_corner),
      .out_valid (blend_valid),
      .out_ready (blend_ready),
      .out_blend (blend_out)
   );

   // ---------------- divide by cell area, sign, saturate, output register
   kab_round u_round (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (blend_valid),
      .in_ready         (blend_ready),
      .in_blend         (blend_out),
      .out_valid        (rsp_valid),
      .out_ready        (rsp_ready),
      .out_compensation (rsp_compensation)
   );

   // ---------------- assertions
   // back-pressure only ever starts at a held response
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without a held response");

   // a write touches at most one parity bank
   a_one_bank: assert property (@(posedge clock) disable iff (reset)
      prep_valid |-> $onehot0(prep_access.wr_en))
      else $error("write enables more than one bank");

   // lookups never write the table
   a_lookup_no_write: assert property (@(posedge clock) disable iff (reset)
      prep_valid && !prep_access.is_write |-> prep_access.wr_en == '0)
      else $error("lookup item carries a bank write");

endmodule
